// File: src/smalu_pkg.sv
// shared types, codes and helpers for the small matrix alu
`default_nettype none

package smalu_pkg;

    localparam int MAX_DIM_DEF   = 8;
    localparam int ELEM_BITS_DEF = 16;
    localparam int IN_BITS       = 16;
    localparam int RES_BITS      = 35;
    localparam int IDX_BITS      = 3;
    localparam int DIM_BITS      = 4;
    localparam int ADDR_FULL     = 6;

    localparam logic [1:0] MODE_LOAD_A = 2'd0;
    localparam logic [1:0] MODE_LOAD_B = 2'd1;
    localparam logic [1:0] MODE_RUN    = 2'd2;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_TRN = 2'd2,
        OP_MUL = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        REG_ROWS_A = 2'd0,
        REG_COLS_A = 2'd1,
        REG_ROWS_B = 2'd2,
        REG_COLS_B = 2'd3
    } t_reg;

    typedef enum logic [2:0] {
        FN_ADD,
        FN_SUB,
        FN_PASS,
        FN_MUL,
        FN_ZERO
    } t_fn;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT
    } t_state;

    typedef struct packed {
        t_fn                 fn;
        logic                first;
        logic                lastk;
        logic [IDX_BITS-1:0] row;
        logic [IDX_BITS-1:0] col;
        logic                status;
        logic                last;
    } t_tag;

    typedef struct packed {
        logic valid;
        t_tag tag;
    } t_issue;

    function automatic logic [DIM_BITS-1:0] dim_clamp(input logic [DIM_BITS-1:0] v,
                                                      input logic [DIM_BITS-1:0] maxd);
        logic [DIM_BITS-1:0] d;
        if (v == '0) begin
            d = DIM_BITS'(1);
        end else if (v > maxd) begin
            d = maxd;
        end else begin
            d = v;
        end
        return d;
    endfunction

    function automatic logic [ADDR_FULL-1:0] elem_addr(input logic [IDX_BITS-1:0] row,
                                                       input logic [IDX_BITS-1:0] col,
                                                       input logic [DIM_BITS-1:0] maxd);
        return ADDR_FULL'(row) * ADDR_FULL'(maxd) + ADDR_FULL'(col);
    endfunction

endpackage

`default_nettype wire

// File: src/small_matrix_alu.sv
// top level: shape registers, element stores, sequencer, shared unit and output register
// load request: taken when the input is not stalled, no result
// run request: result elements pass through the shared unit one at a time, each summing
// cols_a products for multiply and one term otherwise; a shape mismatch gives a single status result
// input is stalled from a run request until its last result sits in the output register
// reset clears control state and sets all shape registers to 1; element stores keep contents
`default_nettype none

module small_matrix_alu
    import smalu_pkg::*;
#(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int ELEM_BITS = ELEM_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic        [1:0]          i_mode,
    input  wire logic        [IDX_BITS-1:0] i_row_index,
    input  wire logic        [IDX_BITS-1:0] i_col_index,
    input  wire logic signed [IN_BITS-1:0]  i_element_value,
    input  wire logic        [1:0]          i_operation,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic signed      [RES_BITS-1:0] o_result_value,
    output logic             [IDX_BITS-1:0] o_result_row,
    output logic             [IDX_BITS-1:0] o_result_col,
    output logic                            o_status,
    output logic                            o_last,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic        [1:0]          i_cfg_index,
    input  wire logic        [DIM_BITS-1:0] i_cfg_data
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [DIM_BITS-1:0] MD = DIM_BITS'(MAX_DIM);

    logic [DIM_BITS-1:0]  r_rows_a, r_cols_a, r_rows_b, r_cols_b;
    logic                 w_in_acc, w_start, w_in_range, w_we_a, w_we_b;
    logic                 w_seq_busy, w_mac_busy, w_done;
    logic signed [31:0]   w_ext;
    logic [ELEM_BITS-1:0] w_elem;
    logic [ADDR_FULL-1:0] w_laddr;
    logic [AW-1:0]        w_raddr_a, w_raddr_b;
    logic [ELEM_BITS-1:0] w_rd_a, w_rd_b;
    t_issue               w_issue;
    t_tag                 w_tag, r_slot_tag;
    logic signed [RES_BITS-1:0] w_acc;
    logic                 r_slot_full, r_out_valid, w_move;
    logic signed [RES_BITS-1:0] r_out_value;
    logic [IDX_BITS-1:0]  r_out_row, r_out_col;
    logic                 r_out_status, r_out_last;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_seq_busy;
    assign w_in_acc    = i_in_valid && !w_seq_busy;
    assign w_start     = w_in_acc && (i_mode == MODE_RUN);

    assign w_ext      = 32'(i_element_value);
    assign w_elem     = w_ext[ELEM_BITS-1:0];
    assign w_in_range = (DIM_BITS'(i_row_index) < MD) && (DIM_BITS'(i_col_index) < MD);
    assign w_laddr    = elem_addr(i_row_index, i_col_index, MD);
    assign w_we_a     = w_in_acc && w_in_range && (i_mode == MODE_LOAD_A);
    assign w_we_b     = w_in_acc && w_in_range && (i_mode == MODE_LOAD_B);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a <= DIM_BITS'(1);
            r_cols_a <= DIM_BITS'(1);
            r_rows_b <= DIM_BITS'(1);
            r_cols_b <= DIM_BITS'(1);
        end else if (i_cfg_valid) begin
            unique case (t_reg'(i_cfg_index))
                REG_ROWS_A: r_rows_a <= i_cfg_data;
                REG_COLS_A: r_cols_a <= i_cfg_data;
                REG_ROWS_B: r_rows_b <= i_cfg_data;
                REG_COLS_B: r_cols_b <= i_cfg_data;
            endcase
        end
    end

    smalu_mem #(
        .DEPTH (DEPTH),
        .WIDTH (ELEM_BITS)
    ) u_mem_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (w_laddr[AW-1:0]),
        .i_wdata (w_elem),
        .i_raddr (w_raddr_a),
        .o_rdata (w_rd_a)
    );

    smalu_mem #(
        .DEPTH (DEPTH),
        .WIDTH (ELEM_BITS)
    ) u_mem_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (w_laddr[AW-1:0]),
        .i_wdata (w_elem),
        .i_raddr (w_raddr_b),
        .o_rdata (w_rd_b)
    );

    smalu_seq #(
        .MAX_DIM (MAX_DIM)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_operation (t_op'(i_operation)),
        .i_rows_a    (r_rows_a),
        .i_cols_a    (r_cols_a),
        .i_rows_b    (r_rows_b),
        .i_cols_b    (r_cols_b),
        .i_pipe_busy (w_mac_busy || r_slot_full),
        .o_issue     (w_issue),
        .o_addr_a    (w_raddr_a),
        .o_addr_b    (w_raddr_b),
        .o_busy      (w_seq_busy)
    );

    smalu_mac #(
        .ELEM_BITS (ELEM_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_issue (w_issue),
        .i_a     (w_rd_a),
        .i_b     (w_rd_b),
        .o_acc   (w_acc),
        .o_done  (w_done),
        .o_tag   (w_tag),
        .o_busy  (w_mac_busy)
    );

    // finished element waits in the accumulator until the output register frees up
    assign w_move = r_slot_full && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_full <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_done) begin
                r_slot_full <= 1'b1;
            end else if (w_move) begin
                r_slot_full <= 1'b0;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_slot_tag <= w_tag;
        end
        if (w_move) begin
            r_out_value  <= w_acc;
            r_out_row    <= r_slot_tag.row;
            r_out_col    <= r_slot_tag.col;
            r_out_status <= r_slot_tag.status;
            r_out_last   <= r_slot_tag.last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_result_row   = r_out_row;
    assign o_result_col   = r_out_col;
    assign o_status       = r_out_status;
    assign o_last         = r_out_last;

endmodule

`default_nettype wire

// File: src/smalu_mem.sv
// single write port, single registered read port element memory
`default_nettype none

module smalu_mem
    import smalu_pkg::*;
#(
    parameter int DEPTH = MAX_DIM_DEF * MAX_DIM_DEF,
    parameter int WIDTH = ELEM_BITS_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: src/smalu_mac.sv
// shared add, subtract, pass, zero and multiply-accumulate unit
`default_nettype none

module smalu_mac
    import smalu_pkg::*;
#(
    parameter int ELEM_BITS = ELEM_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire t_issue                      i_issue,
    input  wire logic        [ELEM_BITS-1:0] i_a,
    input  wire logic        [ELEM_BITS-1:0] i_b,
    output logic signed      [RES_BITS-1:0]  o_acc,
    output logic                             o_done,
    output t_tag                             o_tag,
    output logic                             o_busy
);

    logic                         r_v1, r_v2, r_done;
    t_tag                         r_tag1, r_tag2, r_tag3;
    logic signed [RES_BITS-1:0]   r_term, r_acc;
    logic signed [RES_BITS-1:0]   w_term;
    logic signed [ELEM_BITS-1:0]  w_a, w_b;
    logic signed [2*ELEM_BITS-1:0] w_prod;

    assign w_a    = $signed(i_a);
    assign w_b    = $signed(i_b);
    assign w_prod = w_a * w_b;

    always_comb begin
        unique case (r_tag1.fn)
            FN_ADD:  w_term = RES_BITS'(w_a) + RES_BITS'(w_b);
            FN_SUB:  w_term = RES_BITS'(w_a) - RES_BITS'(w_b);
            FN_PASS: w_term = RES_BITS'(w_a);
            FN_MUL:  w_term = RES_BITS'(w_prod);
            default: w_term = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_issue.valid;
            r_v2   <= r_v1;
            r_done <= r_v2 && r_tag2.lastk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag1 <= i_issue.tag;
        r_tag2 <= r_tag1;
        r_term <= w_term;
        if (r_v2) begin
            r_acc  <= r_tag2.first ? r_term : r_acc + r_term;
            r_tag3 <= r_tag2;
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;
    assign o_tag  = r_tag3;
    assign o_busy = r_v1 || r_v2 || r_done;

endmodule

`default_nettype wire

// File: src/smalu_seq.sv
// run sequencer: walks result elements and inner-product steps
`default_nettype none

module smalu_seq
    import smalu_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF,
    localparam int AW = (MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire t_op                 i_operation,
    input  wire logic [DIM_BITS-1:0] i_rows_a,
    input  wire logic [DIM_BITS-1:0] i_cols_a,
    input  wire logic [DIM_BITS-1:0] i_rows_b,
    input  wire logic [DIM_BITS-1:0] i_cols_b,
    input  wire logic                i_pipe_busy,
    output t_issue                   o_issue,
    output logic      [AW-1:0]       o_addr_a,
    output logic      [AW-1:0]       o_addr_b,
    output logic                     o_busy
);

    localparam logic [DIM_BITS-1:0] MD = DIM_BITS'(MAX_DIM);

    t_state              r_state, n_state;
    t_fn                 r_fn, n_fn;
    logic [IDX_BITS-1:0] r_i, n_i, r_j, n_j, r_k, n_k;
    logic [DIM_BITS-1:0] r_nr, n_nr, r_nc, n_nc, r_nk, n_nk;
    logic                r_mis, n_mis;
    logic [DIM_BITS-1:0] w_ra, w_ca, w_rb, w_cb;
    logic                w_lastk, w_last_elem;
    logic [ADDR_FULL-1:0] w_fa, w_fb;

    assign w_ra = dim_clamp(i_rows_a, MD);
    assign w_ca = dim_clamp(i_cols_a, MD);
    assign w_rb = dim_clamp(i_rows_b, MD);
    assign w_cb = dim_clamp(i_cols_b, MD);

    assign w_lastk     = (DIM_BITS'(r_k) + DIM_BITS'(1)) == r_nk;
    assign w_last_elem = ((DIM_BITS'(r_i) + DIM_BITS'(1)) == r_nr)
                      && ((DIM_BITS'(r_j) + DIM_BITS'(1)) == r_nc);

    always_comb begin
        unique case (r_fn)
            FN_PASS: begin
                w_fa = elem_addr(r_j, r_i, MD);
                w_fb = elem_addr(r_j, r_i, MD);
            end
            FN_MUL: begin
                w_fa = elem_addr(r_i, r_k, MD);
                w_fb = elem_addr(r_k, r_j, MD);
            end
            default: begin
                w_fa = elem_addr(r_i, r_j, MD);
                w_fb = elem_addr(r_i, r_j, MD);
            end
        endcase
    end

    assign o_addr_a = w_fa[AW-1:0];
    assign o_addr_b = w_fb[AW-1:0];
    assign o_busy   = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mis   <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_mis   <= n_mis;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fn <= n_fn;
        r_nr <= n_nr;
        r_nc <= n_nc;
        r_nk <= n_nk;
    end

    always_comb begin
        n_state = r_state;
        n_fn    = r_fn;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_nr    = r_nr;
        n_nc    = r_nc;
        n_nk    = r_nk;
        n_mis   = r_mis;
        o_issue = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_k     = '0;
                    n_mis   = 1'b0;
                    n_nk    = DIM_BITS'(1);
                    n_state = S_ISSUE;
                    unique case (i_operation)
                        OP_ADD, OP_SUB: begin
                            n_nr  = w_ra;
                            n_nc  = w_ca;
                            n_fn  = (i_operation == OP_ADD) ? FN_ADD : FN_SUB;
                            n_mis = (w_ra != w_rb) || (w_ca != w_cb);
                        end
                        OP_TRN: begin
                            n_nr = w_ca;
                            n_nc = w_ra;
                            n_fn = FN_PASS;
                        end
                        OP_MUL: begin
                            n_nr  = w_ra;
                            n_nc  = w_cb;
                            n_nk  = w_ca;
                            n_fn  = FN_MUL;
                            n_mis = (w_ca != w_rb);
                        end
                    endcase
                    if (n_mis) begin
                        n_nr = DIM_BITS'(1);
                        n_nc = DIM_BITS'(1);
                        n_nk = DIM_BITS'(1);
                        n_fn = FN_ZERO;
                    end
                end
            end
            S_ISSUE: begin
                o_issue.valid      = 1'b1;
                o_issue.tag.fn     = r_fn;
                o_issue.tag.first  = (r_k == '0);
                o_issue.tag.lastk  = w_lastk;
                o_issue.tag.row    = r_i;
                o_issue.tag.col    = r_j;
                o_issue.tag.status = r_mis;
                o_issue.tag.last   = w_last_elem;
                if (w_lastk) begin
                    n_state = S_WAIT;
                end else begin
                    n_k = r_k + IDX_BITS'(1);
                end
            end
            S_WAIT: begin
                if (!i_pipe_busy) begin
                    n_k = '0;
                    if (w_last_elem) begin
                        n_state = S_IDLE;
                        n_mis   = 1'b0;
                    end else begin
                        n_state = S_ISSUE;
                        if ((DIM_BITS'(r_j) + DIM_BITS'(1)) == r_nc) begin
                            n_j = '0;
                            n_i = r_i + IDX_BITS'(1);
                        end else begin
                            n_j = r_j + IDX_BITS'(1);
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// File: tb/smalu_checker.sv
// checker for the small matrix alu: watches all channels, predicts result elements, compares
module smalu_checker
    import smalu_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic                       i_in_stall,
    input  wire logic        [1:0]          i_mode,
    input  wire logic        [IDX_BITS-1:0] i_row_index,
    input  wire logic        [IDX_BITS-1:0] i_col_index,
    input  wire logic signed [IN_BITS-1:0]  i_element_value,
    input  wire logic        [1:0]          i_operation,
    input  wire logic                       i_out_valid,
    input  wire logic                       i_out_stall,
    input  wire logic signed [RES_BITS-1:0] i_result_value,
    input  wire logic        [IDX_BITS-1:0] i_result_row,
    input  wire logic        [IDX_BITS-1:0] i_result_col,
    input  wire logic                       i_status,
    input  wire logic                       i_last,
    input  wire logic                       i_cfg_valid,
    input  wire logic                       i_cfg_ready,
    input  wire logic        [1:0]          i_cfg_index,
    input  wire logic        [DIM_BITS-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_MISMATCH = 1'b1;
    localparam int   STORE_DEPTH     = MAX_DIM_DEF * MAX_DIM_DEF;

    typedef struct {
        logic signed [RES_BITS-1:0] value;
        logic        [IDX_BITS-1:0] row;
        logic        [IDX_BITS-1:0] col;
        logic                       status;
        logic                       last;
    } t_matrix_elem;

    logic signed [ELEM_BITS_DEF-1:0] store_a [STORE_DEPTH];
    logic signed [ELEM_BITS_DEF-1:0] store_b [STORE_DEPTH];
    logic        [DIM_BITS-1:0]      rows_a, cols_a, rows_b, cols_b;
    t_matrix_elem                    queued_elems [$];
    int                              fails = 0;
    int                              pending = 0;

    assign o_fail_count = fails;
    assign o_pending    = pending;

    function automatic int clamp_dim(input logic [DIM_BITS-1:0] v);
        if (v == '0) return 1;
        if (v > DIM_BITS'(MAX_DIM_DEF)) return MAX_DIM_DEF;
        return int'(v);
    endfunction

    task automatic push_elem(input logic signed [RES_BITS-1:0] value, input int row,
                             input int col, input logic status, input logic last);
        t_matrix_elem e;
        e.value  = value;
        e.row    = IDX_BITS'(row);
        e.col    = IDX_BITS'(col);
        e.status = status;
        e.last   = last;
        queued_elems.push_back(e);
    endtask

    task automatic compute_run(input t_op op);
        int                         ra, ca, rb, cb, nr, nc;
        logic signed [RES_BITS-1:0] acc, ea, eb;
        ra = clamp_dim(rows_a);
        ca = clamp_dim(cols_a);
        rb = clamp_dim(rows_b);
        cb = clamp_dim(cols_b);
        if (((op == OP_ADD || op == OP_SUB) && (ra != rb || ca != cb)) ||
            (op == OP_MUL && ca != rb)) begin
            push_elem('0, 0, 0, STATUS_MISMATCH, 1'b1);
            return;
        end
        nr = (op == OP_TRN) ? ca : ra;
        nc = (op == OP_TRN) ? ra : ((op == OP_MUL) ? cb : ca);
        for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < nc; j++) begin
                ea = store_a[i * MAX_DIM_DEF + j];
                eb = store_b[i * MAX_DIM_DEF + j];
                case (op)
                    OP_ADD: begin
                        acc = ea + eb;
                    end
                    OP_SUB: begin
                        acc = ea - eb;
                    end
                    OP_TRN: begin
                        acc = store_a[j * MAX_DIM_DEF + i];
                    end
                    default: begin
                        acc = '0;
                        for (int k = 0; k < ca; k++) begin
                            ea  = store_a[i * MAX_DIM_DEF + k];
                            eb  = store_b[k * MAX_DIM_DEF + j];
                            acc = acc + ea * eb;
                        end
                    end
                endcase
                push_elem(acc, i, j, STATUS_OK, (i == nr - 1) && (j == nc - 1));
            end
        end
    endtask

    task automatic check_result();
        t_matrix_elem e;
        if (queued_elems.size() == 0) begin
            $error("unexpected result: value %0d row %0d col %0d status %0d last %0d",
                   i_result_value, i_result_row, i_result_col, i_status, i_last);
            fails++;
            return;
        end
        e = queued_elems.pop_front();
        if (i_result_value !== e.value) begin
            $error("result_value: expected %0d, got %0d", e.value, i_result_value);
            fails++;
        end
        if (i_result_row !== e.row) begin
            $error("result_row: expected %0d, got %0d", e.row, i_result_row);
            fails++;
        end
        if (i_result_col !== e.col) begin
            $error("result_col: expected %0d, got %0d", e.col, i_result_col);
            fails++;
        end
        if (i_status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, i_status);
            fails++;
        end
        if (i_last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, i_last);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rows_a = DIM_BITS'(1);
            cols_a = DIM_BITS'(1);
            rows_b = DIM_BITS'(1);
            cols_b = DIM_BITS'(1);
            queued_elems.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_reg'(i_cfg_index))
                    REG_ROWS_A: rows_a = i_cfg_data;
                    REG_COLS_A: cols_a = i_cfg_data;
                    REG_ROWS_B: rows_b = i_cfg_data;
                    default:    cols_b = i_cfg_data;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_mode == MODE_LOAD_A) begin
                    store_a[{i_row_index, i_col_index}] = i_element_value;
                end else if (i_mode == MODE_LOAD_B) begin
                    store_b[{i_row_index, i_col_index}] = i_element_value;
                end else if (i_mode == MODE_RUN) begin
                    compute_run(t_op'(i_operation));
                end
            end
            if (i_out_valid && !i_out_stall) begin
                check_result();
            end
        end
        pending = queued_elems.size();
    end

endmodule

// File: tb/tb_top.sv
// testbench top for the small matrix alu: clock, reset, request stimulus and verdict
module tb_top;
    import smalu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam int         DRAIN_CYCLES = 16;
    localparam int         HOLD_CYCLES  = 200;
    localparam int         RANDOM_ITEMS = 310;

    logic                       clk         = 1'b0;
    logic                       rst_n       = 1'b0;
    logic                       in_valid    = 1'b0;
    logic                       in_stall;
    logic        [1:0]          in_mode     = MODE_LOAD_A;
    logic        [IDX_BITS-1:0] in_row      = '0;
    logic        [IDX_BITS-1:0] in_col      = '0;
    logic signed [IN_BITS-1:0]  in_value    = '0;
    t_op                        in_op       = OP_ADD;
    logic                       out_valid;
    logic                       out_stall   = 1'b0;
    logic signed [RES_BITS-1:0] res_value;
    logic        [IDX_BITS-1:0] res_row;
    logic        [IDX_BITS-1:0] res_col;
    logic                       res_status;
    logic                       res_last;
    logic                       cfg_valid   = 1'b0;
    logic                       cfg_ready;
    logic        [1:0]          cfg_index   = REG_ROWS_A;
    logic        [DIM_BITS-1:0] cfg_data    = '0;
    int                         fail_count;
    int                         pending;

    bit                         snd_burst   = 1'b0;
    bit                         rcv_burst   = 1'b0;
    bit                         hold_now    = 1'b0;
    int                         sent_count  = 0;
    bit                         a_written [MAX_DIM_DEF * MAX_DIM_DEF];
    bit                         b_written [MAX_DIM_DEF * MAX_DIM_DEF];
    logic        [DIM_BITS-1:0] cur_ra = DIM_BITS'(1), cur_ca = DIM_BITS'(1);
    logic        [DIM_BITS-1:0] cur_rb = DIM_BITS'(1), cur_cb = DIM_BITS'(1);

    small_matrix_alu dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_mode          (in_mode),
        .i_row_index     (in_row),
        .i_col_index     (in_col),
        .i_element_value (in_value),
        .i_operation     (in_op),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_result_value  (res_value),
        .o_result_row    (res_row),
        .o_result_col    (res_col),
        .o_status        (res_status),
        .o_last          (res_last),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    smalu_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_mode          (in_mode),
        .i_row_index     (in_row),
        .i_col_index     (in_col),
        .i_element_value (in_value),
        .i_operation     (in_op),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_result_value  (res_value),
        .i_result_row    (res_row),
        .i_result_col    (res_col),
        .i_status        (res_status),
        .i_last          (res_last),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin : clock_gen
        forever #2 clk = ~clk;
    end

    initial begin : run_limit
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int eff_dim(input logic [DIM_BITS-1:0] v);
        if (v == '0) return 1;
        if (v > DIM_BITS'(MAX_DIM_DEF)) return MAX_DIM_DEF;
        return int'(v);
    endfunction

    function automatic logic [DIM_BITS-1:0] pick_dim();
        int p;
        p = $urandom_range(0, 19);
        if (p < 14) return DIM_BITS'($urandom_range(1, 3));
        if (p < 17) return DIM_BITS'($urandom_range(4, 8));
        if (p == 17) return '0;
        return DIM_BITS'($urandom_range(9, 15));
    endfunction

    function automatic logic signed [IN_BITS-1:0] rand_elem();
        case ($urandom_range(0, 7))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            default: return IN_BITS'($urandom);
        endcase
    endfunction

    function automatic t_op rand_op();
        return t_op'($urandom_range(0, 3));
    endfunction

    task automatic send_request(input logic [1:0] mode, input logic [IDX_BITS-1:0] row,
                                input logic [IDX_BITS-1:0] col,
                                input logic signed [IN_BITS-1:0] value, input t_op op);
        int gap;
        gap = snd_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_mode  <= mode;
        in_row   <= row;
        in_col   <= col;
        in_value <= value;
        in_op    <= op;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (mode == MODE_LOAD_A) a_written[{row, col}] = 1'b1;
        if (mode == MODE_LOAD_B) b_written[{row, col}] = 1'b1;
        if (mode != MODE_UNUSED) sent_count++;
    endtask

    task automatic send_run(input t_op op);
        send_request(MODE_RUN, IDX_BITS'($urandom), IDX_BITS'($urandom), rand_elem(), op);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input t_reg idx, input logic [DIM_BITS-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic write_shapes(input logic [DIM_BITS-1:0] ra, input logic [DIM_BITS-1:0] ca,
                                input logic [DIM_BITS-1:0] rb, input logic [DIM_BITS-1:0] cb);
        cfg_write(REG_ROWS_A, ra);
        cfg_write(REG_COLS_A, ca);
        cfg_write(REG_ROWS_B, rb);
        cfg_write(REG_COLS_B, cb);
        cfg_valid <= 1'b0;
        cur_ra = ra;
        cur_ca = ca;
        cur_rb = rb;
        cur_cb = cb;
    endtask

    // every element a run can read under the current shapes has been written at least once
    task automatic fill_shapes();
        for (int r = 0; r < eff_dim(cur_ra); r++) begin
            for (int c = 0; c < eff_dim(cur_ca); c++) begin
                if (!a_written[r * MAX_DIM_DEF + c] || $urandom_range(0, 7) == 0) begin
                    send_request(MODE_LOAD_A, IDX_BITS'(r), IDX_BITS'(c), rand_elem(),
                                 rand_op());
                end
            end
        end
        for (int r = 0; r < eff_dim(cur_rb); r++) begin
            for (int c = 0; c < eff_dim(cur_cb); c++) begin
                if (!b_written[r * MAX_DIM_DEF + c] || $urandom_range(0, 7) == 0) begin
                    send_request(MODE_LOAD_B, IDX_BITS'(r), IDX_BITS'(c), rand_elem(),
                                 rand_op());
                end
            end
        end
    endtask

    initial begin : result_sink
        int gap;
        int taken;
        taken = 0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (hold_now) begin
                gap      = HOLD_CYCLES;
                hold_now = 1'b0;
            end else if (rcv_burst) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, 5);
            end
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            taken++;
            if (taken % 16 == 0) rcv_burst = ($urandom_range(0, 3) == 0);
        end
    end

    initial begin : stimulus
        int                  phase;
        int                  n;
        int                  p;
        int                  target;
        bit                  hold_done;
        logic [DIM_BITS-1:0] d1, d2, d3, d4;

        hold_done = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset shapes are 1 by 1: extremes of the element range through every operation
        send_request(MODE_LOAD_A, '0, '0, 16'sh7fff, OP_ADD);
        send_request(MODE_LOAD_B, '0, '0, 16'sh7fff, OP_MUL);
        send_run(OP_ADD);
        send_run(OP_SUB);
        send_run(OP_TRN);
        send_run(OP_MUL);
        send_request(MODE_LOAD_A, '0, '0, 16'sh8000, OP_SUB);
        send_request(MODE_LOAD_B, '0, '0, 16'sh8000, OP_TRN);
        send_run(OP_ADD);
        send_run(OP_MUL);
        send_request(MODE_LOAD_B, '0, '0, 16'sh7fff, OP_ADD);
        send_run(OP_SUB);
        send_run(OP_MUL);
        send_request(MODE_UNUSED, IDX_BITS'($urandom), IDX_BITS'($urandom), rand_elem(),
                     rand_op());
        send_run(OP_TRN);

        // zero shape counts as one; shape mismatch for add, subtract and multiply
        wait_drained();
        write_shapes('0, DIM_BITS'(2), DIM_BITS'(1), '0);
        fill_shapes();
        send_run(OP_ADD);
        send_run(OP_MUL);
        send_run(OP_TRN);
        send_run(OP_SUB);

        target = sent_count + RANDOM_ITEMS;
        phase  = 0;
        while (sent_count < target) begin
            wait_drained();
            d1 = pick_dim();
            d2 = pick_dim();
            d3 = pick_dim();
            d4 = pick_dim();
            if (phase == 0) begin
                write_shapes(DIM_BITS'(8), DIM_BITS'(8), DIM_BITS'(8), DIM_BITS'(8));
            end else if (phase == 1) begin
                write_shapes(DIM_BITS'(15), DIM_BITS'(15), DIM_BITS'(15), DIM_BITS'(15));
            end else begin
                case ($urandom_range(0, 3))
                    0:       write_shapes(d1, d1, d1, d1);
                    1:       write_shapes(d1, d2, d2, d3);
                    2:       write_shapes(d1, d2, d1, d2);
                    default: write_shapes(d1, d2, d3, d4);
                endcase
            end
            snd_burst = ($urandom_range(0, 3) == 0);
            fill_shapes();
            n = $urandom_range(3, 10);
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(0, 9) == 0) wait_drained();
                p = $urandom_range(0, 9);
                if (p == 0) begin
                    send_request(MODE_LOAD_A,
                                 IDX_BITS'($urandom_range(0, eff_dim(cur_ra) - 1)),
                                 IDX_BITS'($urandom_range(0, eff_dim(cur_ca) - 1)),
                                 rand_elem(), rand_op());
                end else if (p == 1) begin
                    send_request(MODE_LOAD_B,
                                 IDX_BITS'($urandom_range(0, eff_dim(cur_rb) - 1)),
                                 IDX_BITS'($urandom_range(0, eff_dim(cur_cb) - 1)),
                                 rand_elem(), rand_op());
                end else if (p == 2) begin
                    send_request($urandom_range(0, 1) ? MODE_LOAD_B : MODE_LOAD_A,
                                 IDX_BITS'($urandom), IDX_BITS'($urandom), rand_elem(),
                                 rand_op());
                end else if (p == 3) begin
                    send_request(MODE_UNUSED, IDX_BITS'($urandom), IDX_BITS'($urandom),
                                 rand_elem(), rand_op());
                end else begin
                    // long output hold-off while further requests are still offered
                    if (!hold_done && k < n - 1) begin
                        hold_now  = 1'b1;
                        hold_done = 1'b1;
                    end
                    send_run(rand_op());
                end
            end
            phase++;
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
